// ===== hdl/tctr_pkg.sv =====
// shared types, constants and round-sum function for the tea counter-mode keystream cipher
`default_nettype none
package tctr_pkg;

  localparam int unsigned ROUND_COUNT = 1024;
  localparam int unsigned STAGES      = 2 * ROUND_COUNT;
  localparam logic [31:0] TEA_DELTA   = 32'h9E37_79B9;

  localparam int unsigned IDX_W   = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned IN_W    = IDX_W + DATA_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
    logic [63:0] nonce;
  } cfg_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [DATA_W-1:0] data;
  } stage_t;

  typedef struct packed {
    logic out_full;
    logic skid_full;
  } obuf_status_t;

  // delta times (round + 1), modulo 2^32
  function automatic logic [31:0] round_sum(input int unsigned rnd);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(rnd + 1);
    return prod[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tctr_cfg.sv =====
// configuration registers: key words and nonce
`default_nettype none
module tctr_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [tctr_pkg::CFG_IDX_W-1:0]       wr_index,
  input  wire logic [tctr_pkg::CFG_DATA_W-1:0]      wr_data,
  output tctr_pkg::cfg_t                            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        tctr_pkg::REG_KEY0:  cfg.k0    <= wr_data[31:0];
        tctr_pkg::REG_KEY1:  cfg.k1    <= wr_data[31:0];
        tctr_pkg::REG_KEY2:  cfg.k2    <= wr_data[31:0];
        tctr_pkg::REG_KEY3:  cfg.k3    <= wr_data[31:0];
        tctr_pkg::REG_NONCE: cfg.nonce <= wr_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tctr_half_round.sv =====
// one registered tea half-round: updates word 0 on even halves, word 1 on odd halves
`default_nettype none
module tctr_half_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            odd_half,
  input  wire logic [31:0]     acc,
  input  wire logic [31:0]     key_a,
  input  wire logic [31:0]     key_b,
  input  wire logic            in_valid,
  input  wire tctr_pkg::stage_t in_stage,
  output logic                 out_valid,
  output tctr_pkg::stage_t     out_stage
);

  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] mix;
  logic [31:0] upd;
  tctr_pkg::stage_t stage_next;

  always_comb begin
    src = odd_half ? in_stage.w0 : in_stage.w1;
    dst = odd_half ? in_stage.w1 : in_stage.w0;
    mix = ((src << 4) + key_a) ^ (src + acc) ^ ((src >> 5) + key_b);
    upd = dst + mix;
    stage_next = in_stage;
    if (odd_half) begin
      stage_next.w1 = upd;
    end else begin
      stage_next.w0 = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tctr_obuf.sv =====
// output register with skid stage; pipeline advances while the skid stage is empty
`default_nettype none
module tctr_obuf (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic [tctr_pkg::DATA_W-1:0]   push_data,
  output logic                               out_valid,
  output logic [tctr_pkg::DATA_W-1:0]        out_data,
  input  wire logic                          out_ready,
  output logic                               accept,
  output tctr_pkg::obuf_status_t             status
);

  logic                         skid_valid;
  logic [tctr_pkg::DATA_W-1:0]  skid_data;
  logic                         pop;

  assign pop    = out_valid && out_ready;
  assign accept = !skid_valid;
  assign status = '{out_full: out_valid, skid_full: skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (out_valid && !pop) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tea_ctr_keystream_cipher_unit.sv =====
// top level of the tea counter-mode keystream cipher: input stage, round pipeline, output buffer
//
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   s_tdata: block_index, data_block
// m_*       out  m_tvalid / m_tready   m_tdata: result_block
// cfg_*     in   cfg_valid / cfg_ready cfg_index, cfg_data (key words 0..3, nonce)
//
// one item per cycle sustained while the skid stage is empty; the data path holds one register stage
// per tea half-round plus the input and output registers
// rst is synchronous active high; it clears valid bits and the key and nonce registers
// the whole pipeline holds while the skid stage is occupied; nothing is dropped or repeated
// the skid stage lets a new item enter while a finished result waits on m_tready
`default_nettype none
module tea_ctr_keystream_cipher_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave side
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [tctr_pkg::IN_W-1:0]           s_tdata,   // [31:0] block_index, [95:32] data_block
  // master side
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [tctr_pkg::DATA_W-1:0]              m_tdata,   // [63:0] result_block
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tctr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tctr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tctr_pkg::cfg_t         cfg;
  tctr_pkg::obuf_status_t obuf_status;

  // pipe[0] is the input register, pipe[s+1] is the output of half-round s
  tctr_pkg::stage_t pipe       [0:tctr_pkg::STAGES];
  logic             pipe_valid [0:tctr_pkg::STAGES];

  logic                         en;
  logic [tctr_pkg::DATA_W-1:0]  result;
  logic [tctr_pkg::IDX_W-1:0]   in_index;
  logic [tctr_pkg::DATA_W-1:0]  in_block;

  assign cfg_ready = 1'b1;
  assign s_tready  = en;
  assign in_index  = s_tdata[tctr_pkg::IDX_W-1:0];
  assign in_block  = s_tdata[tctr_pkg::IN_W-1:tctr_pkg::IDX_W];

  tctr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input stage: counter is the zero-extended index xor the nonce
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid[0] <= 1'b0;
    end else if (en) begin
      pipe_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].w0   <= cfg.nonce[31:0] ^ in_index;
      pipe[0].w1   <= cfg.nonce[63:32];
      pipe[0].data <= in_block;
    end
  end

  // round pipeline: even half-rounds update word 0 with k0/k1, odd ones word 1 with k2/k3
  for (genvar g = 0; g < tctr_pkg::STAGES; g++) begin : g_half
    localparam logic [31:0] ACC = tctr_pkg::round_sum(g / 2);
    localparam logic        ODD = (g % 2) == 1;

    tctr_half_round u_half (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .odd_half  (ODD),
      .acc       (ACC),
      .key_a     (ODD ? cfg.k2 : cfg.k0),
      .key_b     (ODD ? cfg.k3 : cfg.k1),
      .in_valid  (pipe_valid[g]),
      .in_stage  (pipe[g]),
      .out_valid (pipe_valid[g+1]),
      .out_stage (pipe[g+1])
    );
  end

  // keystream is word 1 high, word 0 low
  assign result = pipe[tctr_pkg::STAGES].data
                ^ {pipe[tctr_pkg::STAGES].w1, pipe[tctr_pkg::STAGES].w0};

  tctr_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (en && pipe_valid[tctr_pkg::STAGES]),
    .push_data (result),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_ready (m_tready),
    .accept    (en),
    .status    (obuf_status)
  );

  // an occupied skid stage always sits behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    obuf_status.skid_full |-> obuf_status.out_full)
    else $error("skid stage full while output register empty");

  // a stalled pipeline keeps its last stage's item in place
  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pipe_valid[tctr_pkg::STAGES]) && $stable(result))
    else $error("pipeline tail changed during a stall");

  // a write to an index beyond the register list leaves key and nonce untouched
  a_stray_cfg_ignored: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index > tctr_pkg::REG_NONCE) |=> $stable(cfg))
    else $error("configuration changed by a write beyond the register list");

  // the output stage only turns valid after a finished item was pushed into it
  a_pipe_feeds_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |-> $past(en && pipe_valid[tctr_pkg::STAGES]))
    else $error("output stage valid without a source");

endmodule
`default_nettype wire
